>>> rtl/mtfs_pkg.sv
// Package: shared widths, register indexes and payload types for the midtones stretch.
`timescale 1ns / 1ps
`default_nettype none
package mtfs_pkg;

    // Fixed-point format of the pixel and of the clip and balance registers
    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = FRAC_BITS + 1;
    localparam logic [VAL_W-1:0] ONE_VAL = VAL_W'(1) << FRAC_BITS;

    // Product and difference widths through the front stages
    localparam int A_W   = 2 * VAL_W + 2;   // (m - 1) * vf, signed
    localparam int B_W   = 2 * VAL_W + 3;   // (2m - 1) * vf, signed
    localparam int C_W   = 2 * VAL_W;       // m * d, unsigned
    localparam int NUM_W = A_W + 8;         // 255 * (m - 1) * vf, signed
    localparam int DEN_W = B_W + 1;         // (2m - 1) * vf - m * d, signed

    // Quotient is clamped to 8 bits
    localparam int DIV_BITS = 8;
    localparam int CMP_W    = DEN_W + DIV_BITS;
    localparam logic [DIV_BITS-1:0] MAX_OUT = '1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHADOW_CLIP     = 2'd0,
        REG_HIGHLIGHT_CLIP  = 2'd1,
        REG_MIDTONE_BALANCE = 2'd2
    } t_cfg_reg;

    // Channel payloads
    typedef struct packed {
        logic [VAL_W-1:0] pixel_level;
        logic             last_in;
    } t_in;

    typedef struct packed {
        logic [DIV_BITS-1:0] display_value;
        logic                last_out;
    } t_out;

    // Item state through the divider stages
    typedef struct packed {
        logic                last;
        logic                fixed;
        logic [DIV_BITS-1:0] fixed_val;
        logic [NUM_W-1:0]    rem;
        logic [DEN_W-1:0]    den;
        logic [DIV_BITS-1:0] quo;
    } t_div;

endpackage
`default_nettype wire

>>> rtl/mtfs_front.sv
// Front stages: clip test, products, numerator and denominator, sign normalization.
`timescale 1ns / 1ps
`default_nettype none
module mtfs_front (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic [mtfs_pkg::VAL_W-1:0] i_shadow_clip,
    input  wire logic [mtfs_pkg::VAL_W-1:0] i_highlight_clip,
    input  wire logic [mtfs_pkg::VAL_W-1:0] i_midtone_balance,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire mtfs_pkg::t_in            i_data,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output mtfs_pkg::t_div                o_data
);
    import mtfs_pkg::*;

    // Stage 1 registers: offsets and balance terms
    logic                    r_v1;
    logic                    r_last1;
    logic                    r_fixed1;
    logic [DIV_BITS-1:0]     r_fval1;
    logic [VAL_W-1:0]        r_vf1;
    logic [VAL_W-1:0]        r_d1;
    logic [VAL_W-1:0]        r_m1;
    logic signed [VAL_W:0]   r_mm1;
    logic signed [VAL_W+1:0] r_m2m1;

    // Stage 2 registers: products
    logic                    r_v2;
    logic                    r_last2;
    logic                    r_fixed2;
    logic [DIV_BITS-1:0]     r_fval2;
    logic signed [A_W-1:0]   r_a;
    logic signed [B_W-1:0]   r_b;
    logic [C_W-1:0]          r_c;

    // Stage 3 registers: numerator and denominator
    logic                    r_v3;
    logic                    r_last3;
    logic                    r_fixed3;
    logic [DIV_BITS-1:0]     r_fval3;
    logic signed [NUM_W-1:0] r_num;
    logic signed [DEN_W-1:0] r_den;

    // Stage 4 register: normalized item for the divider
    logic                    r_v4;
    t_div                    r_out;

    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    logic                    n_fixed1;
    logic [DIV_BITS-1:0]     n_fval1;
    logic signed [VAL_W:0]   n_mm1;
    logic signed [VAL_W+1:0] n_m2m1;
    logic signed [NUM_W-1:0] n_num;
    logic signed [DEN_W-1:0] n_den;
    logic signed [NUM_W-1:0] n_nmag;
    logic signed [DEN_W-1:0] n_dmag;
    logic                    n_neg;
    logic                    n_zero;

    // Advance a stage when it is empty or the next one takes its item
    assign w_rdy4  = !r_v4 || i_ready;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    // Clip test and balance terms
    always_comb begin
        n_fixed1 = 1'b0;
        n_fval1  = '0;
        if (i_data.pixel_level < i_shadow_clip) begin
            n_fixed1 = 1'b1;
        end else if (i_data.pixel_level >= i_highlight_clip) begin
            n_fixed1 = 1'b1;
            n_fval1  = MAX_OUT;
        end
        n_mm1  = $signed({1'b0, i_midtone_balance}) - $signed({1'b0, ONE_VAL});
        n_m2m1 = $signed({1'b0, i_midtone_balance, 1'b0}) - $signed({2'b00, ONE_VAL});
    end

    // Numerator as 256a - a, denominator as b - c
    always_comb begin
        n_num = (NUM_W'(r_a) <<< 8) - NUM_W'(r_a);
        n_den = DEN_W'(r_b) - $signed(DEN_W'(r_c));
    end

    // Flip signs so the denominator is positive
    always_comb begin
        n_neg  = r_den[DEN_W-1];
        n_nmag = n_neg ? -r_num : r_num;
        n_dmag = n_neg ? -r_den : r_den;
        n_zero = (r_den == '0) || n_nmag[NUM_W-1];
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_last1  <= i_data.last_in;
            r_fixed1 <= n_fixed1;
            r_fval1  <= n_fval1;
            r_vf1    <= i_data.pixel_level - i_shadow_clip;
            r_d1     <= i_highlight_clip - i_shadow_clip;
            r_m1     <= i_midtone_balance;
            r_mm1    <= n_mm1;
            r_m2m1   <= n_m2m1;
        end
        if (w_rdy2) begin
            r_last2  <= r_last1;
            r_fixed2 <= r_fixed1;
            r_fval2  <= r_fval1;
            r_a      <= r_mm1 * $signed({1'b0, r_vf1});
            r_b      <= r_m2m1 * $signed({1'b0, r_vf1});
            r_c      <= r_m1 * r_d1;
        end
        if (w_rdy3) begin
            r_last3  <= r_last2;
            r_fixed3 <= r_fixed2;
            r_fval3  <= r_fval2;
            r_num    <= n_num;
            r_den    <= n_den;
        end
        if (w_rdy4) begin
            r_out.last      <= r_last3;
            r_out.fixed     <= r_fixed3 || n_zero;
            r_out.fixed_val <= r_fixed3 ? r_fval3 : '0;
            r_out.rem       <= $unsigned(n_nmag);
            r_out.den       <= $unsigned(n_dmag);
            r_out.quo       <= '0;
        end
    end

    assign o_valid = r_v4;
    assign o_data  = r_out;

endmodule
`default_nettype wire

>>> rtl/mtfs_div_step.sv
// One restoring division step: compare and subtract the shifted denominator; the top step only flags overflow.
`timescale 1ns / 1ps
`default_nettype none
module mtfs_div_step #(
    parameter int SHIFT = 0
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire mtfs_pkg::t_div i_data,
    output logic                o_valid,
    input  wire logic           i_ready,
    output mtfs_pkg::t_div      o_data
);
    import mtfs_pkg::*;

    logic                r_v;
    t_div                r_item;
    t_div                n_item;
    logic [CMP_W-1:0]    w_rem;
    logic [CMP_W-1:0]    w_sub;
    logic [DIV_BITS:0]   w_bit;
    logic                w_rdy;

    assign w_rdy   = !r_v || i_ready;
    assign o_ready = w_rdy;

    // Top step only detects overflow; lower steps form quotient bits
    always_comb begin
        w_rem  = CMP_W'(i_data.rem);
        w_sub  = CMP_W'(i_data.den) << SHIFT;
        w_bit  = (DIV_BITS + 1)'(1) << SHIFT;
        n_item = i_data;
        if (!i_data.fixed && (w_rem >= w_sub)) begin
            if (SHIFT == DIV_BITS) begin
                n_item.fixed     = 1'b1;
                n_item.fixed_val = MAX_OUT;
            end else begin
                n_item.rem = NUM_W'(w_rem - w_sub);
                n_item.quo = i_data.quo | w_bit[DIV_BITS-1:0];
            end
        end
    end

    // Hold valid and item until the next stage takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_rdy) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_v;
    assign o_data  = r_item;

endmodule
`default_nettype wire

>>> rtl/midtones_transfer_stretch_core.sv
// Top level: configuration registers, front stages and the divider step chain.
// Items pass 4 front stages, then 9 divider steps; the top step only flags overflow.
// Throughput: one item per cycle unless stalled; each other step resolves one quotient bit.
// Backpressure ripples stage by stage, so empty stages keep filling while the output stalls.
// Reset (synchronous, active low) empties the pipeline and loads shadows 0,
// highlights 1.0 and midtones balance 0.5.
`timescale 1ns / 1ps
`default_nettype none
module midtones_transfer_stretch_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [mtfs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [mtfs_pkg::VAL_W-1:0]    i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire mtfs_pkg::t_in                 i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output mtfs_pkg::t_out                     o_out_data
);
    import mtfs_pkg::*;

    localparam int N_STEPS = DIV_BITS + 1;

    logic [VAL_W-1:0] r_shadow_clip;
    logic [VAL_W-1:0] r_highlight_clip;
    logic [VAL_W-1:0] r_midtone_balance;

    t_div w_item  [0:N_STEPS];
    logic w_valid [0:N_STEPS];
    logic w_ready [0:N_STEPS];

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shadow_clip     <= '0;
            r_highlight_clip  <= ONE_VAL;
            r_midtone_balance <= ONE_VAL >> 1;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_SHADOW_CLIP:     r_shadow_clip     <= i_cfg_data;
                REG_HIGHLIGHT_CLIP:  r_highlight_clip  <= i_cfg_data;
                REG_MIDTONE_BALANCE: r_midtone_balance <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mtfs_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_shadow_clip     (r_shadow_clip),
        .i_highlight_clip  (r_highlight_clip),
        .i_midtone_balance (r_midtone_balance),
        .i_valid           (i_in_valid),
        .o_ready           (o_in_ready),
        .i_data            (i_in_data),
        .o_valid           (w_valid[0]),
        .i_ready           (w_ready[0]),
        .o_data            (w_item[0])
    );

    // Divider chain: overflow check first, then quotient bits from MSB down
    for (genvar k = 0; k < N_STEPS; k++) begin : g_step
        mtfs_div_step #(
            .SHIFT (DIV_BITS - k)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_data  (w_item[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_data  (w_item[k+1])
        );
    end

    // Pick the saturated or computed value for the result item
    assign w_ready[N_STEPS] = i_out_ready;
    assign o_out_valid      = w_valid[N_STEPS];
    assign o_out_data       = {(w_item[N_STEPS].fixed ? w_item[N_STEPS].fixed_val
                                                      : w_item[N_STEPS].quo),
                               w_item[N_STEPS].last};

endmodule
`default_nettype wire

>>> tb/tb_midtones_transfer_stretch_core.sv
// Self-checking testbench for the midtones transfer stretch core.
`timescale 1ns / 1ps
module tb_midtones_transfer_stretch_core;
    import mtfs_pkg::*;

    localparam int VAL_MAX     = (1 << VAL_W) - 1;
    localparam int HOLD_CYCLES = 60;
    localparam int DRAIN_WAIT  = 20;
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_MAX  = 10;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // Stretch predictor plus the queue of display values still owed by the core
    class stretch_scoreboard;
        logic [VAL_W-1:0] shadow_lvl;
        logic [VAL_W-1:0] highlight_lvl;
        logic [VAL_W-1:0] balance;
        t_out             display_q[$];
        int               failures;

        function new();
            shadow_lvl    = '0;
            highlight_lvl = ONE_VAL;
            balance       = ONE_VAL >> 1;
            failures      = 0;
        endfunction

        function void set_level(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] val);
            case (idx)
                REG_SHADOW_CLIP:     shadow_lvl    = val;
                REG_HIGHLIGHT_CLIP:  highlight_lvl = val;
                REG_MIDTONE_BALANCE: balance       = val;
                default: ;  // drop writes to unused indexes
            endcase
        endfunction

        // Exact integer form of the stretch, one floor at the end
        function logic [DIV_BITS-1:0] stretch(logic [VAL_W-1:0] pixel);
            longint unit, vf, d, m, num, den, q;
            unit = longint'(1) << FRAC_BITS;
            if (pixel < shadow_lvl) return '0;
            if (pixel >= highlight_lvl) return MAX_OUT;
            vf  = longint'(pixel) - longint'(shadow_lvl);
            d   = longint'(highlight_lvl) - longint'(shadow_lvl);
            m   = longint'(balance);
            num = 255 * (m - unit) * vf;
            den = (2 * m - unit) * vf - m * d;
            if (den == 0) return '0;
            if (den < 0) begin
                den = -den;
                num = -num;
            end
            if (num < 0) return '0;
            q = num / den;
            if (q > 255) return MAX_OUT;
            return q[DIV_BITS-1:0];
        endfunction

        function void note_pixel(t_in item);
            t_out exp_item;
            exp_item.display_value = stretch(item.pixel_level);
            exp_item.last_out      = item.last_in;
            display_q.push_back(exp_item);
        endfunction

        function void report(string what, int exp_val, int got_val);
            failures++;
            if (failures <= REPORT_MAX)
                $display("[%0t] mismatch on %s: expected %0d, got %0d",
                         $time, what, exp_val, got_val);
        endfunction

        function void check_display(t_out got);
            t_out exp_item;
            if (display_q.size() == 0) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("[%0t] unexpected result: display %0d last %0b",
                             $time, got.display_value, got.last_out);
                return;
            end
            exp_item = display_q.pop_front();
            if (got.display_value !== exp_item.display_value)
                report("display_value", int'(exp_item.display_value),
                       int'(got.display_value));
            if (got.last_out !== exp_item.last_out)
                report("last_out", int'(exp_item.last_out), int'(got.last_out));
        endfunction

        function int outstanding();
            return display_q.size();
        endfunction
    endclass

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = REG_SHADOW_CLIP;
    logic [VAL_W-1:0]     cfg_data    = '0;
    logic                 in_valid    = 1'b0;
    t_in                  in_data     = '0;
    logic                 out_ready   = 1'b0;
    logic                 in_ready;
    logic                 out_valid;
    t_out                 out_data;

    stretch_scoreboard    sb          = new();
    bit                   tx_steady   = 1'b0;
    bit                   rx_steady   = 1'b0;
    bit                   rx_hold_req = 1'b0;
    int                   cycle_count = 0;

    midtones_transfer_stretch_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.outstanding());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Write one register, then drop the enable
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_level(idx, val);
        @(posedge clk);
    endtask

    task automatic set_levels(input int shadow, input int highlight, input int balance);
        write_reg(REG_SHADOW_CLIP, shadow[VAL_W-1:0]);
        write_reg(REG_HIGHLIGHT_CLIP, highlight[VAL_W-1:0]);
        write_reg(REG_MIDTONE_BALANCE, balance[VAL_W-1:0]);
    endtask

    // Offer one pixel after a random gap and hold it until accepted
    task automatic send_pixel(input logic [VAL_W-1:0] level, input logic last);
        t_in item;
        int  gap;
        item.pixel_level = level;
        item.last_in     = last;
        gap = tx_steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_pixel(item);
    endtask

    // Stop offering and wait for every owed result
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() > 0) @(posedge clk);
    endtask

    // Mostly land in the middle band, otherwise anywhere, right on a clip edge or at a field extreme
    function automatic logic [VAL_W-1:0] pick_pixel(int shadow, int highlight);
        int r;
        r = $urandom_range(0, 9);
        if (r < 6 && highlight > shadow)
            return VAL_W'($urandom_range(shadow, highlight - 1));
        if (r < 8)
            return VAL_W'($urandom_range(0, VAL_MAX));
        case ($urandom_range(0, 5))
            0: return VAL_W'(shadow - 1);
            1: return VAL_W'(shadow);
            2: return VAL_W'(highlight - 1);
            3: return VAL_W'(highlight);
            4: return '0;
            default: return VAL_W'(VAL_MAX);
        endcase
    endfunction

    task automatic run_phase(input int shadow, input int highlight, input int balance,
                             input int count, input int mode, input bit hold);
        wait_idle();
        set_levels(shadow, highlight, balance);
        tx_steady   = mode[0];
        rx_steady   = mode[1];
        rx_hold_req = hold;
        for (int i = 0; i < count; i++)
            send_pixel(pick_pixel(shadow, highlight), 1'($urandom_range(0, 1)));
    endtask

    // Result side: random stalls, one long hold-off on request, check every item
    initial begin : result_side
        int stall;
        wait (rst_n == 1'b1);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall = rx_steady ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            sb.check_display(out_data);
        end
    end

    initial begin : stimulus
        int shadow, highlight, balance;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset levels: field extremes and both last marks
        send_pixel(0, 1'b0);
        send_pixel(1, 1'b1);
        send_pixel(ONE_VAL >> 1, 1'b0);
        send_pixel(VAL_W'(ONE_VAL - 1), 1'b1);
        send_pixel(ONE_VAL, 1'b0);
        send_pixel(VAL_W'(VAL_MAX), 1'b1);

        // Clip edges; zero balance makes the denominator vanish at the shadow clip
        wait_idle();
        set_levels(16384, 49152, 0);
        send_pixel(16383, 1'b0);
        send_pixel(16384, 1'b1);
        send_pixel(16385, 1'b0);
        send_pixel(49151, 1'b1);
        send_pixel(49152, 1'b0);

        // Balance above 1.0: negative quotient, zero denominator, quotient overflow;
        // the write to the unused index must change nothing
        wait_idle();
        set_levels(0, 1000, 98304);
        write_reg(REG_UNUSED, 17'h1ABCD);
        send_pixel(3, 1'b0);
        send_pixel(750, 1'b1);
        send_pixel(751, 1'b0);
        send_pixel(999, 1'b1);

        // Highlights below shadows: empty middle band
        wait_idle();
        set_levels(40000, 30000, VAL_MAX);
        send_pixel(35000, 1'b0);
        send_pixel(39999, 1'b1);
        send_pixel(40000, 1'b0);
        send_pixel(VAL_W'(VAL_MAX), 1'b1);

        // Both clips at the top of the field
        wait_idle();
        set_levels(VAL_MAX, VAL_MAX, ONE_VAL);
        send_pixel(0, 1'b0);
        send_pixel(VAL_W'(VAL_MAX - 1), 1'b1);
        send_pixel(VAL_W'(VAL_MAX), 1'b0);

        // Random phases over extreme and random level settings
        run_phase(0, ONE_VAL, 0, 90, 0, 1'b0);
        run_phase(0, ONE_VAL, ONE_VAL, 90, 2, 1'b0);
        run_phase(1000, 60000, VAL_MAX, 100, 1, 1'b1);
        run_phase(50000, 20000, 20000, 60, 3, 1'b0);
        for (int p = 0; p < 5; p++) begin
            shadow    = $urandom_range(0, 65536);
            highlight = $urandom_range(shadow, (p == 4) ? VAL_MAX : 65536);
            balance   = (p < 3) ? $urandom_range(0, 65536) : $urandom_range(0, VAL_MAX);
            run_phase(shadow, highlight, balance, 85, p % 4, 1'b0);
        end

        // Drain and let any stray result show up
        wait_idle();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.outstanding() > 0)
            $display("%0d expected results never arrived", sb.outstanding());
        if (sb.failures == 0 && sb.outstanding() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/mtfs_pkg.sv
rtl/mtfs_front.sv
rtl/mtfs_div_step.sv
rtl/midtones_transfer_stretch_core.sv
tb/tb_midtones_transfer_stretch_core.sv
